// ===== src/three_rotor_reflector_cipher_assert.svh =====
// Assertion macros for the three-rotor reflector cipher.
// No dependencies; included by the top level only.
`ifndef THREE_ROTOR_REFLECTOR_CIPHER_ASSERT_SVH
`define THREE_ROTOR_REFLECTOR_CIPHER_ASSERT_SVH
`ifndef SYNTHESIS
`define TRC_ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("trc assertion failed");
`define TRC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("trc assertion failed");
`define TRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("trc assertion failed");
`else
`define TRC_ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define TRC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define TRC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

// ===== src/trc_pkg.sv =====
// Package for the three-rotor reflector cipher: widths, register codes, wiring tables.
// No dependencies; used by the interfaces and the top level.
`default_nettype none
package trc_pkg;
    localparam int LETTERS    = 26;
    localparam int LETTER_W   = 5;
    localparam int PLUG_PAIRS = 10;
    localparam int PAIR_W     = 2 * LETTER_W;
    localparam int PLUG_W     = 50;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = PLUG_W;

    typedef logic [LETTER_W-1:0] t_letter;
    typedef logic [LETTERS-1:0][LETTER_W-1:0] t_wiring;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RING_FAST   = 3'd0,
        REG_RING_MIDDLE = 3'd1,
        REG_RING_SLOW   = 3'd2,
        REG_PLUG_LOW    = 3'd3,
        REG_PLUG_HIGH   = 3'd4
    } t_cfg_reg;

    // ASCII wiring string to letter codes; first character is entry 0
    function automatic t_wiring to_wiring(input logic [8*LETTERS-1:0] s);
        t_wiring w;
        for (int i = 0; i < LETTERS; i++) begin
            w[i] = LETTER_W'(s[8*(LETTERS-i)-1 -: 8] - 8'd65);
        end
        return w;
    endfunction

    function automatic t_wiring invert(input t_wiring w);
        t_wiring r;
        r = '0;
        for (int i = 0; i < LETTERS; i++) begin
            r[w[i]] = LETTER_W'(i);
        end
        return r;
    endfunction

    localparam t_wiring WIRE_FAST   = to_wiring("BDFHJLCPRTXVZNYEIWGAKMUSQO"); // III
    localparam t_wiring WIRE_MIDDLE = to_wiring("AJDKSIRUXBLHWTMCQGZNPYFVOE"); // II
    localparam t_wiring WIRE_SLOW   = to_wiring("EKMFLGDQVZNTOWYHXUSPAIBRCJ"); // I
    localparam t_wiring WIRE_REFL   = to_wiring("YRUHQSLDPXNGOKMIEBFZCWVJAT"); // B
    localparam t_wiring INV_FAST    = invert(WIRE_FAST);
    localparam t_wiring INV_MIDDLE  = invert(WIRE_MIDDLE);
    localparam t_wiring INV_SLOW    = invert(WIRE_SLOW);
endpackage
`default_nettype wire

// ===== src/trc_ifs.sv =====
// Valid/ready channel interfaces for the cipher: input letters, results, config writes.
// Depends on trc_pkg.
`default_nettype none
interface trc_in_if import trc_pkg::*; ();
    logic    valid;
    logic    ready;
    t_letter letter;
    logic    restart;
    modport source (output valid, letter, restart, input ready);
    modport sink (input valid, letter, restart, output ready);
endinterface

interface trc_out_if import trc_pkg::*; ();
    logic    valid;
    logic    ready;
    t_letter cipher_letter;
    modport source (output valid, cipher_letter, input ready);
    modport sink (input valid, cipher_letter, output ready);
endinterface

interface trc_cfg_if import trc_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== src/three_rotor_reflector_cipher.sv =====
// Three-rotor reflector cipher, three-stage pipeline.
// Throughput: one letter per cycle unless the result side stalls a full pipeline.
// Stages: plugboard and rotor positions / forward rotors and reflector / inverse
// rotors and plugboard. Stalls ripple back stage by stage through combinational ready logic; bubbles still fill.
// Reset (i_rst_n low, synchronous) clears rings, plugs, step counters and valids.
// Depends on trc_pkg, trc_ifs and three_rotor_reflector_cipher_assert.svh.
`default_nettype none
`include "three_rotor_reflector_cipher_assert.svh"
module three_rotor_reflector_cipher import trc_pkg::*; (
    input  wire        i_clk,
    input  wire        i_rst_n,
    trc_in_if.sink     i_in,
    trc_out_if.source  o_out,
    trc_cfg_if.sink    i_cfg
);

    // mod-26 helpers; operands always below 26
    function automatic t_letter add26(input t_letter a, input t_letter b);
        logic [LETTER_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= (LETTER_W+1)'(LETTERS)) begin
            s = s - (LETTER_W+1)'(LETTERS);
        end
        return s[LETTER_W-1:0];
    endfunction

    function automatic t_letter sub26(input t_letter a, input t_letter b);
        logic [LETTER_W:0] s;
        s = {1'b0, a} + (LETTER_W+1)'(LETTERS) - {1'b0, b};
        if (s >= (LETTER_W+1)'(LETTERS)) begin
            s = s - (LETTER_W+1)'(LETTERS);
        end
        return s[LETTER_W-1:0];
    endfunction

    // fold codes 26..31 back into range
    function automatic t_letter fold26(input t_letter a);
        return (a >= LETTER_W'(LETTERS)) ? a - LETTER_W'(LETTERS) : a;
    endfunction

    // first valid pair holding the letter decides the swap
    function automatic t_letter plug_swap(input t_letter ch, input logic [PLUG_W-1:0] lo,
                                          input logic [PLUG_W-1:0] hi);
        logic [2*PLUG_W-1:0] all;
        t_letter a;
        t_letter b;
        t_letter res;
        logic    hit;
        all = {hi, lo};
        res = ch;
        hit = 1'b0;
        for (int k = 0; k < PLUG_PAIRS; k++) begin
            a = all[PAIR_W*k +: LETTER_W];
            b = all[PAIR_W*k+LETTER_W +: LETTER_W];
            if (!hit && a < LETTER_W'(LETTERS) && b < LETTER_W'(LETTERS) && a != b) begin
                if (ch == a) begin
                    res = b;
                    hit = 1'b1;
                end else if (ch == b) begin
                    res = a;
                    hit = 1'b1;
                end
            end
        end
        return res;
    endfunction

    // ---------------- configuration ----------------
    t_letter           r_ring_fast, r_ring_middle, r_ring_slow;
    logic [PLUG_W-1:0] r_plug_low, r_plug_high;
    logic              cfg_we;

    assign i_cfg.ready = 1'b1;
    assign cfg_we      = i_cfg.valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ring_fast   <= '0;
            r_ring_middle <= '0;
            r_ring_slow   <= '0;
            r_plug_low    <= '0;
            r_plug_high   <= '0;
        end else if (cfg_we) begin
            unique case (i_cfg.index)
                REG_RING_FAST:   r_ring_fast   <= i_cfg.data[LETTER_W-1:0];
                REG_RING_MIDDLE: r_ring_middle <= i_cfg.data[LETTER_W-1:0];
                REG_RING_SLOW:   r_ring_slow   <= i_cfg.data[LETTER_W-1:0];
                REG_PLUG_LOW:    r_plug_low    <= i_cfg.data;
                REG_PLUG_HIGH:   r_plug_high   <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // ---------------- pipeline handshake ----------------
    logic r_s1_v, r_s2_v, r_s3_v;
    logic s3_ld, s2_ld, s1_ld, in_beat;

    assign s3_ld   = !r_s3_v || o_out.ready;
    assign s2_ld   = !r_s2_v || s3_ld;
    assign s1_ld   = !r_s1_v || s2_ld;
    assign in_beat = i_in.valid && s1_ld;

    assign i_in.ready = s1_ld;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_v <= 1'b0;
            r_s2_v <= 1'b0;
            r_s3_v <= 1'b0;
        end else begin
            if (s1_ld) r_s1_v <= i_in.valid;
            if (s2_ld) r_s2_v <= r_s1_v;
            if (s3_ld) r_s3_v <= r_s2_v;
        end
    end

    // ---------------- step counters ----------------
    // Restart clears before the advance, so the first letter is step 1.
    t_letter r_fast_step, r_middle_step, r_slow_step;
    t_letter n_fast_step, n_middle_step, n_slow_step;
    t_letter base_f, base_m, base_s;
    logic    carry_m, carry_s;

    always_comb begin
        base_f  = i_in.restart ? '0 : r_fast_step;
        base_m  = i_in.restart ? '0 : r_middle_step;
        base_s  = i_in.restart ? '0 : r_slow_step;
        carry_m = (base_f == LETTER_W'(LETTERS-1));
        carry_s = carry_m && (base_m == LETTER_W'(LETTERS-1));
        n_fast_step   = carry_m ? '0 : base_f + 1'b1;
        n_middle_step = carry_m ? (carry_s ? '0 : base_m + 1'b1) : base_m;
        n_slow_step   = carry_s ? ((base_s == LETTER_W'(LETTERS-1)) ? '0 : base_s + 1'b1)
                                : base_s;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fast_step   <= '0;
            r_middle_step <= '0;
            r_slow_step   <= '0;
        end else if (in_beat) begin
            r_fast_step   <= n_fast_step;
            r_middle_step <= n_middle_step;
            r_slow_step   <= n_slow_step;
        end
    end

    // ---------------- stage 1: plugboard in, rotor positions ----------------
    t_letter r_s1_x, r_s1_pf, r_s1_pm, r_s1_ps;

    always_ff @(posedge i_clk) begin
        if (s1_ld) begin
            r_s1_x  <= plug_swap(fold26(i_in.letter), r_plug_low, r_plug_high);
            r_s1_pf <= add26(fold26(r_ring_fast), n_fast_step);
            r_s1_pm <= add26(fold26(r_ring_middle), n_middle_step);
            r_s1_ps <= add26(fold26(r_ring_slow), n_slow_step);
        end
    end

    // ---------------- stage 2: forward rotors, reflector ----------------
    t_letter r_s2_x, r_s2_pf, r_s2_pm, r_s2_ps;
    t_letter f1, f2, f3;

    always_comb begin
        f1 = WIRE_FAST[sub26(r_s1_x, r_s1_pf)];
        f2 = WIRE_MIDDLE[sub26(f1, r_s1_pm)];
        f3 = WIRE_SLOW[sub26(f2, r_s1_ps)];
    end

    always_ff @(posedge i_clk) begin
        if (s2_ld) begin
            r_s2_x  <= WIRE_REFL[f3];
            r_s2_pf <= r_s1_pf;
            r_s2_pm <= r_s1_pm;
            r_s2_ps <= r_s1_ps;
        end
    end

    // ---------------- stage 3: inverse rotors, plugboard out ----------------
    t_letter r_s3_x;
    t_letter b1, b2, b3;

    always_comb begin
        b1 = add26(INV_SLOW[r_s2_x], r_s2_ps);
        b2 = add26(INV_MIDDLE[b1], r_s2_pm);
        b3 = add26(INV_FAST[b2], r_s2_pf);
    end

    always_ff @(posedge i_clk) begin
        if (s3_ld) begin
            r_s3_x <= plug_swap(b3, r_plug_low, r_plug_high);
        end
    end

    assign o_out.valid         = r_s3_v;
    assign o_out.cipher_letter = r_s3_x;

    // ---------------- checks ----------------
    `TRC_ASSERT_ALWAYS(a_step_range, i_clk, i_rst_n, r_fast_step < LETTER_W'(LETTERS) && r_middle_step < LETTER_W'(LETTERS) && r_slow_step < LETTER_W'(LETTERS))
    `TRC_ASSERT_NEXT(a_restart_step, i_clk, i_rst_n, in_beat && i_in.restart, r_fast_step == LETTER_W'(1) && r_middle_step == '0 && r_slow_step == '0)
    `TRC_ASSERT_IMPL(a_stall_full, i_clk, i_rst_n, !i_in.ready, r_s1_v && r_s2_v && r_s3_v)
    `TRC_ASSERT_IMPL(a_out_range, i_clk, i_rst_n, o_out.valid, o_out.cipher_letter < LETTER_W'(LETTERS))

endmodule
`default_nettype wire

// ===== tb/tb.sv =====
`timescale 1ns / 100ps
// Self-checking bench for the three-rotor reflector cipher. A short directed script runs
// first, then random messages under random rings and plugboards; a predictor checks them.
// Depends on trc_pkg, the channel interfaces in trc_ifs and the cipher top level.
module tb;
    import trc_pkg::*;

    localparam int HALF_PERIOD   = 10;
    localparam int RESET_CYCLES  = 6;
    localparam int PIPE_DEPTH    = 3;     // input beat to result beat, per the top level
    localparam int QUIET_LIMIT   = 1000;  // cycles without any beat before giving up
    localparam int LONG_HOLD     = 64;
    localparam int REPORT_MAX    = 10;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 130;
    localparam int LONG_MESSAGE  = 720;   // runs past step 676, so the slow rotor moves
    localparam int CODE_MAX      = (1 << LETTER_W) - 1;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = '1;  // decodes to no register

    // Rotor wirings as ASCII, entry 0 first: III fast, II middle, I slow, reflector B
    localparam logic [8*LETTERS-1:0] ROTOR_FAST   = "BDFHJLCPRTXVZNYEIWGAKMUSQO";
    localparam logic [8*LETTERS-1:0] ROTOR_MIDDLE = "AJDKSIRUXBLHWTMCQGZNPYFVOE";
    localparam logic [8*LETTERS-1:0] ROTOR_SLOW   = "EKMFLGDQVZNTOWYHXUSPAIBRCJ";
    localparam logic [8*LETTERS-1:0] REFLECTOR    = "YRUHQSLDPXNGOKMIEBFZCWVJAT";

    typedef struct packed {
        t_letter plain;
        t_letter cipher;
    } t_cipher_due;

    typedef struct packed {
        logic [LETTER_W-1:0] ring_f;
        logic [LETTER_W-1:0] ring_m;
        logic [LETTER_W-1:0] ring_s;
        logic [PLUG_W-1:0]   plug_lo;
        logic [PLUG_W-1:0]   plug_hi;
    } t_rotor_setting;

    // Directed script row; cipher is only meaningful where known is set
    typedef struct packed {
        logic [1:0]          phase;
        logic [LETTER_W-1:0] letter;
        logic                restart;
        logic                known;
        t_letter             cipher;
    } t_script_row;

    // Phase 0 runs on reset values, phase 1 on extreme rings and a full plugboard,
    // phase 2 on rings above Z and a plugboard with overlaps and dead pairs.
    // Known answers: A at step 1 with everything at reset gives I; the machine is
    // its own inverse, so I at step 1 gives A; code 26 folds back to A.
    localparam int SCRIPT_ROWS = 23;
    localparam t_script_row SCRIPT [SCRIPT_ROWS] = '{
        '{2'd0, 5'd0,  1'b0, 1'b1, 5'd8},   // first letter after reset is step 1
        '{2'd0, 5'd8,  1'b1, 1'b1, 5'd0},
        '{2'd0, 5'd26, 1'b1, 1'b1, 5'd8},
        '{2'd0, 5'd31, 1'b0, 1'b0, 5'd0},
        '{2'd0, 5'd25, 1'b0, 1'b0, 5'd0},
        '{2'd0, 5'd0,  1'b1, 1'b1, 5'd8},
        '{2'd0, 5'd13, 1'b0, 1'b0, 5'd0},
        '{2'd1, 5'd0,  1'b1, 1'b0, 5'd0},
        '{2'd1, 5'd25, 1'b0, 1'b0, 5'd0},
        '{2'd1, 5'd9,  1'b0, 1'b0, 5'd0},
        '{2'd1, 5'd16, 1'b0, 1'b0, 5'd0},
        '{2'd1, 5'd31, 1'b1, 1'b0, 5'd0},
        '{2'd1, 5'd12, 1'b0, 1'b0, 5'd0},
        '{2'd2, 5'd0,  1'b1, 1'b0, 5'd0},   // A sits in two pairs: first one wins
        '{2'd2, 5'd1,  1'b0, 1'b0, 5'd0},
        '{2'd2, 5'd2,  1'b0, 1'b0, 5'd0},
        '{2'd2, 5'd3,  1'b0, 1'b0, 5'd0},   // D paired with itself: no swap
        '{2'd2, 5'd4,  1'b0, 1'b0, 5'd0},   // E paired with code 31: no swap
        '{2'd2, 5'd5,  1'b0, 1'b0, 5'd0},
        '{2'd2, 5'd6,  1'b0, 1'b0, 5'd0},
        '{2'd2, 5'd12, 1'b0, 1'b0, 5'd0},
        '{2'd2, 5'd24, 1'b0, 1'b0, 5'd0},
        '{2'd2, 5'd25, 1'b1, 1'b0, 5'd0}
    };

    logic clk = 1'b0;
    logic rst_n;

    trc_in_if  in_ch ();
    trc_out_if out_ch ();
    trc_cfg_if cfg_ch ();

    three_rotor_reflector_cipher i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .i_cfg   (cfg_ch)
    );

    always begin
        #HALF_PERIOD clk = 1'b1;
        #HALF_PERIOD clk = 1'b0;
    end

    // Predictor state: a copy of the registers and the three step counters
    logic [LETTER_W-1:0] ring_fast   = '0;
    logic [LETTER_W-1:0] ring_middle = '0;
    logic [LETTER_W-1:0] ring_slow   = '0;
    logic [PLUG_W-1:0]   plugs_low   = '0;
    logic [PLUG_W-1:0]   plugs_high  = '0;
    int fast_count   = 0;
    int middle_count = 0;
    int slow_count   = 0;

    t_cipher_due ciphers_due [$];
    int          failures      = 0;
    bit          idle_on       = 1'b0;
    int          hold_requests = 0;
    logic        script_known;    // travels with the input beat
    t_letter     script_cipher;

    function automatic void log_failure(input string msg);
        if (failures < REPORT_MAX) begin
            $display("%s", msg);
        end
        failures++;
    endfunction

    function automatic int wire_code(input logic [8*LETTERS-1:0] w, input int i);
        return int'(w[8*(LETTERS-1-i) +: 8]) - int'("A");
    endfunction

    // Rotor at position pos: forward x -> W[x - pos], backward c -> W^-1[c] + pos
    function automatic int rotor_forward(input logic [8*LETTERS-1:0] w, input int x,
                                         input int pos);
        return wire_code(w, (x + LETTERS - pos) % LETTERS);
    endfunction

    function automatic int rotor_backward(input logic [8*LETTERS-1:0] w, input int c,
                                          input int pos);
        int found;
        found = 0;
        for (int i = 0; i < LETTERS; i++) begin
            if (wire_code(w, i) == c) found = i;
        end
        return (found + pos) % LETTERS;
    endfunction

    // First live pair holding the letter decides; pairs with equal or out-of-range
    // letters are dead
    function automatic int plug_partner(input int ch);
        logic [PLUG_W-1:0] word;
        int a, b;
        for (int k = 0; k < PLUG_PAIRS; k++) begin
            word = (k < PLUG_PAIRS / 2) ? plugs_low : plugs_high;
            a = int'(word[PAIR_W*(k % (PLUG_PAIRS/2)) +: LETTER_W]);
            b = int'(word[PAIR_W*(k % (PLUG_PAIRS/2)) + LETTER_W +: LETTER_W]);
            if (a < LETTERS && b < LETTERS && a != b) begin
                if (ch == a) return b;
                if (ch == b) return a;
            end
        end
        return ch;
    endfunction

    // Steps the rotors, then runs the letter through the full path
    function automatic t_letter encipher(input logic [LETTER_W-1:0] letter,
                                         input logic restart);
        int x, pf, pm, ps;
        if (restart) begin
            fast_count   = 0;
            middle_count = 0;
            slow_count   = 0;
        end
        fast_count = (fast_count + 1) % LETTERS;
        if (fast_count == 0) begin
            middle_count = (middle_count + 1) % LETTERS;
            if (middle_count == 0) slow_count = (slow_count + 1) % LETTERS;
        end
        pf = (int'(ring_fast) % LETTERS + fast_count) % LETTERS;
        pm = (int'(ring_middle) % LETTERS + middle_count) % LETTERS;
        ps = (int'(ring_slow) % LETTERS + slow_count) % LETTERS;
        x = plug_partner(int'(letter) % LETTERS);
        x = rotor_forward(ROTOR_FAST, x, pf);
        x = rotor_forward(ROTOR_MIDDLE, x, pm);
        x = rotor_forward(ROTOR_SLOW, x, ps);
        x = wire_code(REFLECTOR, x);
        x = rotor_backward(ROTOR_SLOW, x, ps);
        x = rotor_backward(ROTOR_MIDDLE, x, pm);
        x = rotor_backward(ROTOR_FAST, x, pf);
        return t_letter'(plug_partner(x));
    endfunction

    // Beat monitor, sampled at the rising edge. Register writes land in the predictor,
    // input beats queue their cipher letter, result beats are checked in order.
    always @(posedge clk) begin : beat_monitor
        t_cipher_due due;
        if (rst_n) begin
            if (cfg_ch.valid && cfg_ch.ready) begin
                case (cfg_ch.index)
                    REG_RING_FAST:   ring_fast   = cfg_ch.data[LETTER_W-1:0];
                    REG_RING_MIDDLE: ring_middle = cfg_ch.data[LETTER_W-1:0];
                    REG_RING_SLOW:   ring_slow   = cfg_ch.data[LETTER_W-1:0];
                    REG_PLUG_LOW:    plugs_low   = cfg_ch.data;
                    REG_PLUG_HIGH:   plugs_high  = cfg_ch.data;
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready) begin
                due.plain  = in_ch.letter;
                due.cipher = encipher(in_ch.letter, in_ch.restart);
                // the counters still step above, but a scripted answer takes precedence
                if (script_known) due.cipher = script_cipher;
                ciphers_due = {ciphers_due, due};
            end
            if (out_ch.valid && out_ch.ready) begin
                if (ciphers_due.size() == 0) begin
                    log_failure($sformatf("cipher letter %0d with nothing due",
                                          out_ch.cipher_letter));
                end else begin
                    due = ciphers_due.pop_front();
                    if (out_ch.cipher_letter !== due.cipher) begin
                        log_failure($sformatf("plain %0d: cipher expected %0d, got %0d",
                                              due.plain, due.cipher, out_ch.cipher_letter));
                    end
                end
            end
        end
    end

    // Result side: random stall bursts while idling is on, plus a long hold each time one is requested
    initial begin : result_sink
        int holds_done, hold_left, stall_left;
        holds_done   = 0;
        hold_left    = 0;
        stall_left   = 0;
        out_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (holds_done != hold_requests) begin
                holds_done = hold_requests;
                hold_left  = LONG_HOLD;
            end
            if (hold_left > 0) begin
                hold_left--;
                out_ch.ready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                out_ch.ready <= 1'b0;
            end else if (idle_on && $urandom_range(0, 4) == 0) begin
                stall_left = $urandom_range(0, 4);
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Ends the run if no beat moves on any channel for too long
    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)
                    || (cfg_ch.valid && cfg_ch.ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("TB_ERROR");
        $finish;
    end

    // Called at a falling edge; returns at the falling edge after the beat, valid left high
    task automatic send_letter(input logic [LETTER_W-1:0] letter, input logic restart,
                               input logic known, input t_letter cipher);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(negedge clk);
        end
        in_ch.valid   <= 1'b1;
        in_ch.letter  <= letter;
        in_ch.restart <= restart;
        script_known  <= known;
        script_cipher <= cipher;
        do @(posedge clk); while (!in_ch.ready);
        @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index,
                             input logic [PLUG_W-1:0] data);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= index;
        cfg_ch.data  <= data;
        do @(posedge clk); while (!cfg_ch.ready);
        @(negedge clk);
    endtask

    task automatic apply_setting(input t_rotor_setting s);
        write_reg(REG_RING_FAST, PLUG_W'(s.ring_f));
        write_reg(REG_RING_MIDDLE, PLUG_W'(s.ring_m));
        write_reg(REG_RING_SLOW, PLUG_W'(s.ring_s));
        write_reg(REG_PLUG_LOW, s.plug_lo);
        write_reg(REG_PLUG_HIGH, s.plug_hi);
        cfg_ch.valid <= 1'b0;
    endtask

    // Stop sending and wait for the pipeline to empty; safe point for register writes
    task automatic pause_until_empty();
        in_ch.valid <= 1'b0;
        while (ciphers_due.size() != 0) @(posedge clk);
        repeat (PIPE_DEPTH + 1) @(posedge clk);
        @(negedge clk);
    endtask

    function automatic logic [PAIR_W-1:0] plug_pair(input int a, input int b);
        return {LETTER_W'(b), LETTER_W'(a)};
    endfunction

    function automatic logic [LETTER_W-1:0] random_letter();
        if ($urandom_range(0, 15) == 0) return LETTER_W'($urandom_range(LETTERS, CODE_MAX));
        return LETTER_W'($urandom_range(0, LETTERS - 1));
    endfunction

    function automatic logic [LETTER_W-1:0] random_ring();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return LETTER_W'(LETTERS - 1);
            2:       return LETTER_W'($urandom_range(LETTERS, CODE_MAX));
            default: return LETTER_W'($urandom_range(0, LETTERS - 1));
        endcase
    endfunction

    // Mostly live pairs (overlaps allowed), some raw bit patterns, some dead pairs
    function automatic logic [PLUG_W-1:0] random_plugs();
        logic [PLUG_W-1:0] word;
        int a;
        word = '0;
        for (int k = 0; k < PLUG_PAIRS / 2; k++) begin
            a = $urandom_range(0, LETTERS - 1);
            case ($urandom_range(0, 9)) inside
                [7:8]:   word[k*PAIR_W +: PAIR_W] = PAIR_W'($urandom);
                9:       word[k*PAIR_W +: PAIR_W] = plug_pair(a, a);
                default: word[k*PAIR_W +: PAIR_W] = plug_pair(a, $urandom_range(0, LETTERS - 1));
            endcase
        end
        return word;
    endfunction

    function automatic t_rotor_setting random_setting();
        t_rotor_setting s;
        s.ring_f  = random_ring();
        s.ring_m  = random_ring();
        s.ring_s  = random_ring();
        s.plug_lo = random_plugs();
        s.plug_hi = random_plugs();
        return s;
    endfunction

    // Restart on the first letter; stray restarts inside a message are noise
    task automatic send_message(input int length, input bit stray_restarts);
        logic restart;
        for (int i = 0; i < length; i++) begin
            restart = (i == 0) || (stray_restarts && $urandom_range(0, 39) == 0);
            send_letter(random_letter(), restart, 1'b0, '0);
        end
    endtask

    initial begin : stimulus
        t_rotor_setting directed_setting [3];
        int phase, sent, length;

        rst_n         = 1'b0;
        in_ch.valid   = 1'b0;
        in_ch.letter  = '0;
        in_ch.restart = 1'b0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = '0;
        cfg_ch.data   = '0;
        script_known  = 1'b0;
        script_cipher = '0;

        directed_setting[0] = '0;
        // top rings; ten live pairs mirroring A-J onto Z-Q
        directed_setting[1].ring_f  = LETTER_W'(LETTERS - 1);
        directed_setting[1].ring_m  = LETTER_W'(LETTERS - 1);
        directed_setting[1].ring_s  = LETTER_W'(LETTERS - 1);
        directed_setting[1].plug_lo = {plug_pair(4, 21), plug_pair(3, 22), plug_pair(2, 23),
                                       plug_pair(1, 24), plug_pair(0, 25)};
        directed_setting[1].plug_hi = {plug_pair(9, 16), plug_pair(8, 17), plug_pair(7, 18),
                                       plug_pair(6, 19), plug_pair(5, 20)};
        // rings above Z fold mod 26; A and B each sit in two pairs, dead pairs mixed in
        directed_setting[2].ring_f  = LETTER_W'(LETTERS);
        directed_setting[2].ring_m  = LETTER_W'(CODE_MAX);
        directed_setting[2].ring_s  = LETTER_W'(CODE_MAX - 1);
        directed_setting[2].plug_lo = {plug_pair(27, 5), plug_pair(4, CODE_MAX),
                                       plug_pair(3, 3), plug_pair(0, 2), plug_pair(0, 1)};
        directed_setting[2].plug_hi = {plug_pair(10, 28), plug_pair(12, 13),
                                       plug_pair(CODE_MAX, CODE_MAX), plug_pair(25, 24),
                                       plug_pair(1, 6)};

        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n   <= 1'b1;
        idle_on = 1'b1;

        // Directed script; registers change only with the pipeline empty
        phase = 0;
        foreach (SCRIPT[r]) begin
            if (int'(SCRIPT[r].phase) != phase) begin
                phase = int'(SCRIPT[r].phase);
                pause_until_empty();
                if (phase == 2) write_reg(REG_SPARE, PLUG_W'({$urandom, $urandom}));
                apply_setting(directed_setting[phase]);
            end
            send_letter(SCRIPT[r].letter, SCRIPT[r].restart, SCRIPT[r].known,
                        SCRIPT[r].cipher);
        end
        pause_until_empty();

        // Random messages, a fresh setting per phase. Phase 1 holds the result side off
        // for a long stretch, phase 3 is one long message across the middle-rotor wrap,
        // and the last phase runs with no idling at all.
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            apply_setting(random_setting());
            if (p == RANDOM_PHASES - 1) idle_on = 1'b0;
            if (p == 1) hold_requests++;
            if (p == 3) begin
                send_message(LONG_MESSAGE, 1'b0);
            end else begin
                sent = 0;
                while (sent < PHASE_ITEMS) begin
                    length = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80)
                                                         : $urandom_range(1, 20);
                    send_message(length, 1'b1);
                    sent += length;
                end
            end
            pause_until_empty();
        end

        repeat (2 * PIPE_DEPTH + 2) @(posedge clk);
        if (ciphers_due.size() != 0) begin
            log_failure($sformatf("%0d cipher letters never arrived", ciphers_due.size()));
        end
        if (failures == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
